### hw/rtl/tgr_pkg.sv
// shared types, constants and codes for the touch gesture recognizer
`timescale 1ns / 1ps

package tgr_pkg;

    localparam int COORD_BITS = 13;
    localparam int TIME_BITS  = 32;
    localparam int WIN_BITS   = 16;
    localparam int DIST_BITS  = 2 * COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    // time, finger count, phase and four coordinates, padded to whole bytes
    localparam int IN_BITS    = ((TIME_BITS + 5 + 4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 8;
    localparam int CFG_BITS   = 16;

    localparam logic [COORD_BITS-1:0] TAP_RADIUS_RST      = COORD_BITS'(22);
    localparam logic [COORD_BITS-1:0] SWIPE_DISTANCE_RST  = COORD_BITS'(86);
    localparam logic [WIN_BITS-1:0]   DOUBLE_TAP_RST      = WIN_BITS'(300);
    localparam logic [WIN_BITS-1:0]   LONG_PRESS_RST      = WIN_BITS'(500);

    typedef enum logic [1:0] {
        REG_TAP_RADIUS     = 2'd0,
        REG_SWIPE_DISTANCE = 2'd1,
        REG_DOUBLE_TAP     = 2'd2,
        REG_LONG_PRESS     = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_NEXT   = 3'd1,
        CMD_PREV   = 3'd2,
        CMD_RESET  = 3'd3,
        CMD_SWAP   = 3'd4,
        CMD_TOGGLE = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        PH_BEGAN      = 3'd0,
        PH_MOVED      = 3'd1,
        PH_STATIONARY = 3'd2,
        PH_ENDED      = 3'd3,
        PH_CANCELED   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  time_ms;
        logic [1:0]            finger_count;
        logic [2:0]            phase;
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
    } item_t;

    typedef struct packed {
        logic            has_command;
        logic [2:0]      command_code;
        logic            user_active;
    } result_t;

    typedef struct packed {
        logic [DIST_BITS-2:0]  radius_sq;
        logic [COORD_BITS-1:0] swipe_distance;
        logic [WIN_BITS-1:0]   double_tap_window;
        logic [WIN_BITS-1:0]   long_press_time;
    } cfg_t;

    typedef struct packed {
        logic                  tap_pending;
        logic [TIME_BITS-1:0]  tap_pending_time;
        logic                  skip_next_release;
        logic                  drag_active;
        logic                  finger_held;
        logic                  long_press_done;
        logic [COORD_BITS-1:0] press_x;
        logic [COORD_BITS-1:0] press_y;
        logic [TIME_BITS-1:0]  press_time;
        logic                  pair_active;
        logic                  pair_moved;
        logic [COORD_BITS-1:0] pair_first_x;
        logic [COORD_BITS-1:0] pair_first_y;
        logic [COORD_BITS-1:0] pair_second_x;
        logic [COORD_BITS-1:0] pair_second_y;
    } state_t;

endpackage

### hw/rtl/tgr_dist.sv
// squared distance between two points compared against the squared tap radius
`timescale 1ns / 1ps

module tgr_dist
(
    input  logic [tgr_pkg::COORD_BITS-1:0] ax,
    input  logic [tgr_pkg::COORD_BITS-1:0] ay,
    input  logic [tgr_pkg::COORD_BITS-1:0] bx,
    input  logic [tgr_pkg::COORD_BITS-1:0] by,
    input  logic [tgr_pkg::DIST_BITS-2:0]  radius_sq,
    output logic                           beyond
);

    logic [tgr_pkg::COORD_BITS-1:0] abs_dx;
    logic [tgr_pkg::COORD_BITS-1:0] abs_dy;
    logic [tgr_pkg::SQ_BITS-1:0]    sq_dx;
    logic [tgr_pkg::SQ_BITS-1:0]    sq_dy;
    logic [tgr_pkg::DIST_BITS-1:0]  dist_sq;

    always_comb
    begin
        abs_dx  = (ax >= bx) ? ax - bx : bx - ax;
        abs_dy  = (ay >= by) ? ay - by : by - ay;
        sq_dx   = tgr_pkg::SQ_BITS'(abs_dx) * tgr_pkg::SQ_BITS'(abs_dx);
        sq_dy   = tgr_pkg::SQ_BITS'(abs_dy) * tgr_pkg::SQ_BITS'(abs_dy);
        dist_sq = tgr_pkg::DIST_BITS'(sq_dx) + tgr_pkg::DIST_BITS'(sq_dy);
        beyond  = dist_sq > tgr_pkg::DIST_BITS'(radius_sq);
    end

endmodule

### hw/rtl/tgr_core.sv
// gesture state register and the per-sample decision logic
`timescale 1ns / 1ps

module tgr_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  tgr_pkg::item_t    item,
    input  tgr_pkg::cfg_t     cfg,
    output tgr_pkg::result_t  result,
    output tgr_pkg::state_t   state
);

    tgr_pkg::state_t              state_reg;
    tgr_pkg::state_t              state_next;
    tgr_pkg::cmd_t                cmd;
    logic                         active;
    logic                         moved_first;
    logic                         moved_second;
    logic                         moved_press;
    logic [tgr_pkg::TIME_BITS-1:0] tap_elapsed;
    logic [tgr_pkg::COORD_BITS:0]  swipe_dx;
    logic [tgr_pkg::COORD_BITS-1:0] swipe_ax;
    logic [tgr_pkg::COORD_BITS-1:0] swipe_ay;

    tgr_dist u_dist_first
    (
        .ax        (item.first_x),
        .ay        (item.first_y),
        .bx        (state_reg.pair_first_x),
        .by        (state_reg.pair_first_y),
        .radius_sq (cfg.radius_sq),
        .beyond    (moved_first)
    );

    tgr_dist u_dist_second
    (
        .ax        (item.second_x),
        .ay        (item.second_y),
        .bx        (state_reg.pair_second_x),
        .by        (state_reg.pair_second_y),
        .radius_sq (cfg.radius_sq),
        .beyond    (moved_second)
    );

    tgr_dist u_dist_press
    (
        .ax        (item.first_x),
        .ay        (item.first_y),
        .bx        (state_reg.press_x),
        .by        (state_reg.press_y),
        .radius_sq (cfg.radius_sq),
        .beyond    (moved_press)
    );

    always_comb
    begin
        tap_elapsed   = item.time_ms - state_reg.tap_pending_time;
        swipe_dx      = {1'b0, item.first_x} - {1'b0, state_reg.press_x};
        swipe_ax      = swipe_dx[tgr_pkg::COORD_BITS] ?
                        tgr_pkg::COORD_BITS'(-swipe_dx) : swipe_dx[tgr_pkg::COORD_BITS-1:0];
        swipe_ay      = (item.first_y >= state_reg.press_y) ?
                        item.first_y - state_reg.press_y : state_reg.press_y - item.first_y;

        state_next = state_reg;
        cmd        = tgr_pkg::CMD_NONE;
        active     = 1'b0;

        // pending tap expires once the window has passed
        if (state_next.tap_pending &&
            tap_elapsed >= tgr_pkg::TIME_BITS'(cfg.double_tap_window))
        begin
            state_next.tap_pending = 1'b0;
        end

        if (item.finger_count >= 2'd2)
        begin
            active                       = 1'b1;
            state_next.tap_pending       = 1'b0;
            state_next.skip_next_release = 1'b0;
            state_next.drag_active       = 1'b0;
            state_next.finger_held       = 1'b0;
            state_next.long_press_done   = 1'b0;
            if (!state_reg.pair_active)
            begin
                state_next.pair_active   = 1'b1;
                state_next.pair_moved    = 1'b0;
                state_next.pair_first_x  = item.first_x;
                state_next.pair_first_y  = item.first_y;
                state_next.pair_second_x = item.second_x;
                state_next.pair_second_y = item.second_y;
            end
            else if (moved_first || moved_second)
            begin
                state_next.pair_moved = 1'b1;
            end
        end
        else if (state_reg.pair_active)
        begin
            if (!state_reg.pair_moved)
            begin
                cmd = tgr_pkg::CMD_SWAP;
            end
            state_next.pair_active       = 1'b0;
            state_next.pair_moved        = 1'b0;
            state_next.tap_pending       = 1'b0;
            state_next.skip_next_release = 1'b0;
            state_next.drag_active       = 1'b0;
            state_next.finger_held       = 1'b0;
            state_next.long_press_done   = 1'b0;
        end
        else if (item.finger_count == 2'd1)
        begin
            case (item.phase)
                tgr_pkg::PH_BEGAN:
                begin
                    active                     = 1'b1;
                    state_next.press_x         = item.first_x;
                    state_next.press_y         = item.first_y;
                    state_next.press_time      = item.time_ms;
                    state_next.finger_held     = 1'b1;
                    state_next.drag_active     = 1'b0;
                    state_next.long_press_done = 1'b0;
                    // a live pending tap is always inside the window here
                    if (state_next.tap_pending)
                    begin
                        state_next.tap_pending       = 1'b0;
                        state_next.skip_next_release = 1'b1;
                        cmd                          = tgr_pkg::CMD_RESET;
                    end
                end
                tgr_pkg::PH_MOVED:
                begin
                    if (state_reg.drag_active || moved_press)
                    begin
                        state_next.drag_active = 1'b1;
                        state_next.tap_pending = 1'b0;
                    end
                end
                tgr_pkg::PH_ENDED:
                begin
                    if (state_reg.skip_next_release)
                    begin
                        state_next.skip_next_release = 1'b0;
                    end
                    else if (state_reg.long_press_done)
                    begin
                        state_next.long_press_done = 1'b0;
                    end
                    else if (state_reg.drag_active)
                    begin
                        if (swipe_ax >= cfg.swipe_distance && swipe_ax > swipe_ay)
                        begin
                            cmd = (!swipe_dx[tgr_pkg::COORD_BITS] && swipe_dx != '0) ?
                                  tgr_pkg::CMD_NEXT : tgr_pkg::CMD_PREV;
                        end
                    end
                    else if (state_reg.finger_held)
                    begin
                        state_next.tap_pending      = 1'b1;
                        state_next.tap_pending_time = item.time_ms;
                    end
                    state_next.drag_active     = 1'b0;
                    state_next.finger_held     = 1'b0;
                    state_next.long_press_done = 1'b0;
                end
                tgr_pkg::PH_CANCELED:
                begin
                    state_next.tap_pending       = 1'b0;
                    state_next.skip_next_release = 1'b0;
                    state_next.drag_active       = 1'b0;
                    state_next.finger_held       = 1'b0;
                    state_next.long_press_done   = 1'b0;
                end
                default:
                begin
                end
            endcase

            // long press: uses the press time as it stands after the phase action
            if (state_next.finger_held && !state_next.drag_active &&
                !state_next.long_press_done &&
                (item.time_ms - state_next.press_time) >=
                tgr_pkg::TIME_BITS'(cfg.long_press_time))
            begin
                cmd                        = tgr_pkg::CMD_TOGGLE;
                state_next.long_press_done = 1'b1;
                state_next.tap_pending     = 1'b0;
            end
        end

        if (cmd != tgr_pkg::CMD_NONE)
        begin
            active = 1'b1;
        end
        result.has_command  = (cmd != tgr_pkg::CMD_NONE);
        result.command_code = cmd;
        result.user_active  = active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

### hw/rtl/touch_gesture_recognizer.sv
// Touch gesture recognizer: turns one touch sample per request into a
// gesture command and a user-activity flag.
// Input channel s_*: one request per touch poll. Output channel m_*: exactly
// one result per request, in order. Config port: cfg_we with cfg_index
// selects tap_radius, swipe_distance, double_tap_window or long_press_time;
// write only while no request is in flight.
// Path: a request accepted into the input register passes through the gesture
// logic into the output register, which drives m_tvalid and m_tdata.
// Throughput: one request per cycle while m_tready is high. The input
// register feeds the gesture logic (three squared-distance compares, time
// compares) whose result and state update land in the output register and
// the state register together. When m_tready is low the output register
// holds its result, the input register takes one more request, and s_tready
// then drops until m_tready returns. Reset clears all gesture state, loads
// the default thresholds and empties both registers.
`timescale 1ns / 1ps

module touch_gesture_recognizer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // time_ms, finger_count, phase, first_x, first_y, second_x, second_y, zero pad
    input  logic [tgr_pkg::IN_BITS-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // has_command, command_code, user_active, zero pad
    output logic [tgr_pkg::OUT_BITS-1:0]  m_tdata,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [tgr_pkg::CFG_BITS-1:0]  cfg_data
);

    localparam int CB = tgr_pkg::COORD_BITS;
    localparam int TB = tgr_pkg::TIME_BITS;

    logic              in_valid_reg;
    logic              in_valid_next;
    tgr_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    tgr_pkg::result_t  out_result_reg;
    tgr_pkg::result_t  core_result;
    tgr_pkg::state_t   core_state;
    tgr_pkg::cfg_t     cfg_reg;
    tgr_pkg::cfg_t     cfg_next;
    tgr_pkg::item_t    s_item;
    logic              advance;
    logic              s_accept;

    always_comb
    begin
        s_item.time_ms      = s_tdata[TB-1:0];
        s_item.finger_count = s_tdata[TB+1:TB];
        s_item.phase        = s_tdata[TB+4:TB+2];
        s_item.first_x      = s_tdata[TB+5+CB-1:TB+5];
        s_item.first_y      = s_tdata[TB+5+2*CB-1:TB+5+CB];
        s_item.second_x     = s_tdata[TB+5+3*CB-1:TB+5+2*CB];
        s_item.second_y     = s_tdata[TB+5+4*CB-1:TB+5+3*CB];
    end

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign s_accept       = s_tvalid && s_tready;
    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    tgr_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_result),
        .state   (core_state)
    );

    // tap radius is held squared so the distance compare needs no extra multiply
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (tgr_pkg::cfg_reg_t'(cfg_index))
                tgr_pkg::REG_TAP_RADIUS:
                    cfg_next.radius_sq = tgr_pkg::SQ_BITS'(cfg_data[CB-1:0]) *
                                         tgr_pkg::SQ_BITS'(cfg_data[CB-1:0]);
                tgr_pkg::REG_SWIPE_DISTANCE:
                    cfg_next.swipe_distance = cfg_data[CB-1:0];
                tgr_pkg::REG_DOUBLE_TAP:
                    cfg_next.double_tap_window = cfg_data;
                tgr_pkg::REG_LONG_PRESS:
                    cfg_next.long_press_time = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            cfg_reg.radius_sq         <= tgr_pkg::SQ_BITS'(tgr_pkg::TAP_RADIUS_RST) *
                                         tgr_pkg::SQ_BITS'(tgr_pkg::TAP_RADIUS_RST);
            cfg_reg.swipe_distance    <= tgr_pkg::SWIPE_DISTANCE_RST;
            cfg_reg.double_tap_window <= tgr_pkg::DOUBLE_TAP_RST;
            cfg_reg.long_press_time   <= tgr_pkg::LONG_PRESS_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.user_active,
                       out_result_reg.command_code, out_result_reg.has_command};

    // a command always counts as activity and carries a nonzero code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] != tgr_pkg::CMD_NONE)))
        else $error("has_command disagrees with command_code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[4])
        else $error("command without user activity");

    // single-finger tracking is idle while a two-finger touch is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        core_state.pair_active |-> (!core_state.drag_active && !core_state.finger_held &&
                                    !core_state.tap_pending && !core_state.long_press_done))
        else $error("single-touch flags set during a pair");

    // a buffered request is never dropped while the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input register lost a request");

    // a completed request always produces a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result missing after advance");

endmodule
